// File: rtl/sstf_pkg.sv
package sstf_pkg;

   // sizes of the request table and the request fields
   localparam int DEPTH       = 16;
   localparam int SECTOR_BITS = 48;
   localparam int TAG_BITS    = 8;
   localparam int IDX_BITS    = $clog2(DEPTH);
   localparam int CNT_BITS    = $clog2(DEPTH + 1);

   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   typedef enum logic [1:0] {
      ST_DISPATCHED = 2'd0,
      ST_ADDED      = 2'd1,
      ST_EMPTY      = 2'd2,
      ST_FULL       = 2'd3
   } status_type;

   typedef enum logic {
      FN_ADD      = 1'b0,
      FN_DISPATCH = 1'b1
   } func_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [SECTOR_BITS-1:0] sector;
      logic [TAG_BITS-1:0]    tag;
   } entry_type;

   typedef struct packed {
      func_type               func;
      logic [SECTOR_BITS-1:0] sector;
      logic [TAG_BITS-1:0]    tag;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [SECTOR_BITS-1:0] out_sector;
      logic [TAG_BITS-1:0]    out_tag;
      logic [CNT_BITS-1:0]    pending;
   } rsp_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic                add_en;
      logic                del_en;
      entry_type           ins;
      logic [IDX_BITS-1:0] cursor;
      logic [CNT_BITS-1:0] count;
   } cell_ctrl_type;

   // cursor candidate offered by the cell under the cursor
   typedef struct packed {
      entry_type ent;
      logic      go_prev;
      logic      cur_le;
   } pick_type;

endpackage

// File: rtl/sstf_cell.sv
module sstf_cell
   import sstf_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_entry,
   input  logic          left_le,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          le,
   output pick_type      pick
);

   entry_type              entry_ff;
   entry_type              entry_in;
   logic                   occupied;
   logic                   is_cur;
   logic                   has_prev;
   logic                   has_next;
   logic [SECTOR_BITS-1:0] dprev;
   logic [SECTOR_BITS-1:0] dnext;

   assign occupied = CNT_BITS'(INDEX) < ctrl.count;
   assign is_cur   = ctrl.cursor == IDX_BITS'(INDEX);
   assign has_prev = INDEX != 0;
   assign has_next = CNT_BITS'(INDEX + 1) < ctrl.count;

   // entry stays put on add when it sorts at or below the new sector
   assign le = occupied && (entry_ff.sector <= ctrl.ins.sector);

   // distances to both neighbors, seen from the cursor position
   assign dprev = entry_ff.sector - left_entry.sector;
   assign dnext = right_entry.sector - entry_ff.sector;

   // offer own entry and the cursor move when under the cursor
   always_comb begin
      pick = '0;
      if (is_cur) begin
         pick.ent     = entry_ff;
         pick.go_prev = has_prev && (has_next ? (dprev < dnext) : 1'b1);
         pick.cur_le  = le;
      end
   end

   // insert, shift up on add; shift down at and above the cursor on dispatch
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.add_en && !le) begin
         entry_in = left_le ? ctrl.ins : left_entry;
      end else if (ctrl.del_en && (IDX_BITS'(INDEX) >= ctrl.cursor)) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: rtl/sstf_request_scheduler_top.sv
// Shortest-seek-time-first request scheduler.
// Requests enter on req_payload with start; a request is taken at a clock
// edge where start is high and busy is low. func adds a request (sector, tag)
// to a table of 16 cells kept sorted by sector, or dispatches the request
// under the cursor, after which the cursor moves to the nearer neighbor.
// For each request, the accept edge registers the request and the cursor
// candidate from the cell chain, then the execute cycle (busy high) shifts
// the chain and updates count and cursor. No new request is taken while
// busy is high, so each request finishes its execute cycle first.
// The response appears on rsp_payload with rsp_valid for exactly one cycle,
// the cycle after the execute cycle. The receiver cannot stall, so nothing
// waits on it.
// A synchronous active-high reset empties the table (count and cursor zero)
// and drops any request in flight; stored entries are not cleared.
module sstf_request_scheduler_top
   import sstf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   state_type           state_ff, state_in;
   req_type             req_ff;
   pick_type            pick_ff;
   pick_type            pick_all;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0] cursor_ff, cursor_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                exec;
   logic                do_add;
   logic                do_del;
   cell_ctrl_type       ctrl;

   entry_type entries [DEPTH];
   logic      les     [DEPTH];
   pick_type  picks   [DEPTH];

   // next state
   always_comb begin
      case (state_ff)
         S_IDLE:  state_in = start ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      case (state_ff)
         S_IDLE:  exec = 1'b0;
         S_EXEC:  exec = 1'b1;
         default: exec = 1'b0;
      endcase
   end

   assign busy   = exec;
   assign accept = start && !busy;

   assign do_add = exec && (req_ff.func == FN_ADD) && (count_ff != FULL_COUNT);
   assign do_del = exec && (req_ff.func == FN_DISPATCH) && (count_ff != '0);

   // broadcast control to the chain
   always_comb begin
      ctrl.add_en     = do_add;
      ctrl.del_en     = do_del;
      ctrl.ins.sector = req_ff.sector;
      ctrl.ins.tag    = req_ff.tag;
      ctrl.cursor     = cursor_ff;
      ctrl.count      = count_ff;
   end

   // build the chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_l;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_l = 1'b1;
      end else begin : g_mid
         assign left_e = entries[i-1];
         assign left_l = les[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = entries[i+1];
      end
      sstf_cell #(.INDEX(i)) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_entry  (left_e),
         .left_le     (left_l),
         .right_entry (right_e),
         .entry       (entries[i]),
         .le          (les[i]),
         .pick        (picks[i])
      );
   end

   // gather the candidate of the cell under the cursor
   always_comb begin
      pick_all = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pick_all = pick_all | picks[i];
      end
   end

   // count, cursor and response of the execute cycle
   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      rsp_in    = '0;
      if (req_ff.func == FN_ADD) begin
         if (count_ff == FULL_COUNT) begin
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.status = ST_ADDED;
            count_in      = count_ff + 1'b1;
            if (count_ff == '0) begin
               cursor_in = '0;
            end else if (!pick_all.cur_le) begin
               cursor_in = cursor_ff + 1'b1;
            end
         end
      end else begin
         if (count_ff == '0) begin
            rsp_in.status = ST_EMPTY;
         end else begin
            rsp_in.status     = ST_DISPATCHED;
            rsp_in.out_sector = pick_ff.ent.sector;
            rsp_in.out_tag    = pick_ff.ent.tag;
            count_in          = count_ff - 1'b1;
            if (count_in == '0) begin
               cursor_in = '0;
            end else if (pick_ff.go_prev) begin
               cursor_in = cursor_ff - 1'b1;
            end
         end
      end
      rsp_in.pending = count_in;
   end

   assign rsp_valid_in = exec;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
      end
   end

   // hold the request and cursor candidate; register the response
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff  <= req_payload;
         pick_ff <= pick_all;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
